[rtl/lps_pkg.sv]
`timescale 1ns / 1ps
package lps_pkg;

  localparam int MAX_SITES_DEF = 4096;
  localparam int MAX_DIMS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 14;

  localparam int SITE_PORT_W = 12;
  localparam int LEN_W       = 7;
  localparam int NDIM_CFG_W  = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int NUM_LEN     = 4;
  localparam int SUM_W       = 30;
  localparam int COUNT_W     = 15;
  localparam int PART_W      = 16;
  localparam int VOL_W       = 28;

  localparam logic signed [SUM_W:0] SUM_LIMIT = 31'sd402653184;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIMS = 3'd0,
    CFG_LEN0     = 3'd1,
    CFG_LEN1     = 3'd2,
    CFG_LEN2     = 3'd3,
    CFG_LEN3     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic mem_we;
    logic init;
    logic setup;
    logic rd;
    logic ld;
    logic mul;
    logic rnd;
    logic acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic setup_last;
    logic vol_err;
    logic k_zero;
    logic k_last;
    logic walk_last;
  } status_t;

endpackage

[rtl/lps_ctrl.sv]
`timescale 1ns / 1ps
module lps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lps_pkg::status_t st,
  output lps_pkg::cmd_t    cmd
);
  import lps_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_RD    = 9'b000001000,
    S_LD    = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_RND   = 9'b001000000,
    S_ACC   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cmd.init  = 1'b1;
            state_nxt = S_SETUP;
          end else begin
            cmd.mem_we = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (st.setup_last) state_nxt = S_CHECK;
      end
      S_CHECK: state_nxt = st.vol_err ? S_DONE : S_RD;
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = st.k_zero ? S_LD : S_MUL;
      end
      S_LD: begin
        cmd.ld    = 1'b1;
        state_nxt = S_RD;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = st.k_last ? S_ACC : S_RD;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = st.walk_last ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/lps_datapath.sv]
`timescale 1ns / 1ps
module lps_datapath #(
  parameter int MAX_SITES = lps_pkg::MAX_SITES_DEF,
  parameter int MAX_DIMS  = lps_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lps_pkg::cmd_t                         cmd,
  output lps_pkg::status_t                      st,
  input  logic                                  cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [lps_pkg::SITE_PORT_W-1:0]       in_site,
  input  logic [1:0]                            in_link_dir,
  input  logic signed [lps_pkg::PART_W-1:0]     in_link_re,
  input  logic signed [lps_pkg::PART_W-1:0]     in_link_im,
  output logic signed [lps_pkg::SUM_W-1:0]      out_plaquette_sum,
  output logic [lps_pkg::COUNT_W-1:0]           out_plaquette_count,
  output logic                                  out_size_error
);
  import lps_pkg::*;

  localparam int DEPTH  = MAX_SITES * MAX_DIMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SITE_W = $clog2(MAX_SITES);
  localparam int DIM_W  = $clog2(MAX_DIMS);
  localparam int ND_W   = $clog2(MAX_DIMS + 1);
  localparam int PROD_W = 2 * (PART_W + 1);
  localparam int RS_W   = PROD_W + 2;
  localparam logic signed [RS_W-1:0] RND_HALF = RS_W'(1) <<< (FRAC_BITS - 1);

  // configuration
  logic [NDIM_CFG_W-1:0] cfg_nd_r;
  logic [LEN_W-1:0]      cfg_len_r [NUM_LEN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nd_r <= NDIM_CFG_W'(4);
      for (int i = 0; i < NUM_LEN; i++) cfg_len_r[i] <= LEN_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_DIMS: cfg_nd_r     <= cfg_data[NDIM_CFG_W-1:0];
        CFG_LEN0:     cfg_len_r[0] <= cfg_data;
        CFG_LEN1:     cfg_len_r[1] <= cfg_data;
        CFG_LEN2:     cfg_len_r[2] <= cfg_data;
        CFG_LEN3:     cfg_len_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [ND_W-1:0]  nd;
  logic [LEN_W-1:0] len_eff [MAX_DIMS];

  always_comb begin
    if (cfg_nd_r < NDIM_CFG_W'(2))             nd = ND_W'(2);
    else if (cfg_nd_r > NDIM_CFG_W'(MAX_DIMS)) nd = ND_W'(MAX_DIMS);
    else                                       nd = cfg_nd_r[ND_W-1:0];
  end

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_len
    assign len_eff[g] = (cfg_len_r[g] == '0) ? LEN_W'(1) : cfg_len_r[g];
  end

  // walk state
  logic [VOL_W-1:0]  vol_r;
  logic [DIM_W-1:0]  d_r;
  logic [SITE_W-1:0] stride_r [MAX_DIMS];
  logic [SITE_W-1:0] wrap_r   [MAX_DIMS];
  logic [LEN_W-1:0]  coord_r  [MAX_DIMS];
  logic [LEN_W-1:0]  coord_nxt [MAX_DIMS];
  logic [SITE_W-1:0] site_r;
  logic [DIM_W-1:0]  mu_r, nu_r;
  logic [1:0]        k_r;
  logic [VOL_W-1:0]  vol_nxt;
  logic              nu_last, mu_last;

  assign vol_nxt = VOL_W'(vol_r * VOL_W'(len_eff[d_r]));
  assign nu_last = (ND_W'(nu_r) == ND_W'(nd - 1'b1));
  assign mu_last = (ND_W'(mu_r) == ND_W'(nd - ND_W'(2)));

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      coord_nxt[i] = coord_r[i];
      if (carry && (ND_W'(i) < nd)) begin
        if (coord_r[i] == len_eff[i] - 1'b1) begin
          coord_nxt[i] = '0;
        end else begin
          coord_nxt[i] = coord_r[i] + 1'b1;
          carry        = 1'b0;
        end
      end
    end
  end

  // neighbor sites and read address
  logic [SITE_W-1:0] x_mu, x_nu, rsite;
  logic [DIM_W-1:0]  rdir;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              load_ok;

  assign x_mu = (coord_r[mu_r] == len_eff[mu_r] - 1'b1) ? site_r - wrap_r[mu_r]
                                                        : site_r + stride_r[mu_r];
  assign x_nu = (coord_r[nu_r] == len_eff[nu_r] - 1'b1) ? site_r - wrap_r[nu_r]
                                                        : site_r + stride_r[nu_r];

  always_comb begin
    case (k_r)
      2'd0:    begin rsite = site_r; rdir = mu_r; end
      2'd1:    begin rsite = site_r; rdir = nu_r; end
      2'd2:    begin rsite = x_mu;   rdir = nu_r; end
      default: begin rsite = x_nu;   rdir = mu_r; end
    endcase
  end

  assign raddr = ADDR_W'(ADDR_W'(rsite) * ADDR_W'(MAX_DIMS) + ADDR_W'(rdir));
  assign waddr = ADDR_W'(ADDR_W'(in_site) * ADDR_W'(MAX_DIMS) + ADDR_W'(in_link_dir));
  assign load_ok = (17'(in_site) < 17'(MAX_SITES)) && ({1'b0, in_link_dir} < 3'(MAX_DIMS));

  // link store
  logic [2*PART_W-1:0] mem [DEPTH];
  logic [2*PART_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we && load_ok) mem[waddr] <= {in_link_im, in_link_re};
    if (cmd.rd) rdata_r <= mem[raddr];
  end

  // complex multiply
  logic signed [PART_W-1:0] p_re_r, p_im_r;
  logic signed [PART_W:0]   a_re, a_im, b_re, b_im;
  logic signed [PROD_W-1:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [PROD_W-1:0] pp_rr_r, pp_ii_r, pp_ri_r, pp_ir_r;
  logic signed [RS_W-1:0]   s_re, s_im;
  logic signed [SUM_W:0]    acc_sum;
  logic signed [SUM_W-1:0]  acc_r;
  logic [COUNT_W-1:0]       count_r;

  assign a_re = p_re_r;
  assign a_im = p_im_r;
  assign b_re = $signed(rdata_r[PART_W-1:0]);
  assign b_im = k_r[0] ? -($signed({rdata_r[2*PART_W-1], rdata_r[2*PART_W-1:PART_W]}))
                       : $signed({rdata_r[2*PART_W-1], rdata_r[2*PART_W-1:PART_W]});
  assign m_rr = a_re * b_re;
  assign m_ii = a_im * b_im;
  assign m_ri = a_re * b_im;
  assign m_ir = a_im * b_re;
  assign s_re = RS_W'(pp_rr_r) - RS_W'(pp_ii_r);
  assign s_im = RS_W'(pp_ri_r) + RS_W'(pp_ir_r);

  function automatic logic signed [PART_W-1:0] rnd_sat(input logic signed [RS_W-1:0] v);
    logic signed [RS_W-1:0] t;
    t = (v + RND_HALF) >>> FRAC_BITS;
    if (t > RS_W'(32767))       rnd_sat = 16'sh7fff;
    else if (t < -RS_W'(32768)) rnd_sat = 16'sh8000;
    else                        rnd_sat = t[PART_W-1:0];
  endfunction

  assign acc_sum = (SUM_W+1)'(acc_r) + (SUM_W+1)'(p_re_r);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      vol_r   <= VOL_W'(1);
      d_r     <= '0;
      acc_r   <= '0;
      count_r <= '0;
      site_r  <= '0;
      mu_r    <= '0;
      nu_r    <= DIM_W'(1);
      k_r     <= '0;
      for (int i = 0; i < MAX_DIMS; i++) coord_r[i] <= '0;
    end
    if (cmd.setup) begin
      d_r <= d_r + 1'b1;
      if (ND_W'(d_r) < nd) begin
        stride_r[d_r] <= SITE_W'(vol_r);
        wrap_r[d_r]   <= SITE_W'(vol_nxt - vol_r);
        vol_r         <= vol_nxt;
      end
    end
    if (cmd.ld) begin
      p_re_r <= $signed(rdata_r[PART_W-1:0]);
      p_im_r <= $signed(rdata_r[2*PART_W-1:PART_W]);
      k_r    <= k_r + 1'b1;
    end
    if (cmd.mul) begin
      pp_rr_r <= m_rr;
      pp_ii_r <= m_ii;
      pp_ri_r <= m_ri;
      pp_ir_r <= m_ir;
    end
    if (cmd.rnd) begin
      p_re_r <= rnd_sat(s_re);
      p_im_r <= rnd_sat(s_im);
      k_r    <= k_r + 1'b1;
    end
    if (cmd.acc) begin
      if (acc_sum > SUM_LIMIT)       acc_r <= SUM_W'(SUM_LIMIT);
      else if (acc_sum < -SUM_LIMIT) acc_r <= SUM_W'(-SUM_LIMIT);
      else                           acc_r <= acc_sum[SUM_W-1:0];
      count_r <= count_r + 1'b1;
      k_r     <= '0;
      if (!nu_last) begin
        nu_r <= nu_r + 1'b1;
      end else if (!mu_last) begin
        mu_r <= mu_r + 1'b1;
        nu_r <= mu_r + DIM_W'(2);
      end else begin
        mu_r    <= '0;
        nu_r    <= DIM_W'(1);
        site_r  <= site_r + 1'b1;
        coord_r <= coord_nxt;
      end
    end
    if (cmd.out_load) begin
      out_plaquette_sum   <= acc_r;
      out_plaquette_count <= count_r;
      out_size_error      <= st.vol_err;
    end
  end

  assign st.setup_last = (d_r == DIM_W'(MAX_DIMS - 1));
  assign st.vol_err    = (vol_r > VOL_W'(MAX_SITES));
  assign st.k_zero     = (k_r == 2'd0);
  assign st.k_last     = (k_r == 2'd3);
  assign st.walk_last  = nu_last && mu_last && (site_r == SITE_W'(vol_r - 1'b1));

endmodule

[rtl/lattice_plaquette_sum.sv]
`timescale 1ns / 1ps
// U(1) lattice plaquette sum. A load request (kind 0) writes one Q2.14 link
// into the link store and returns nothing. A measure request (kind 1) walks
// every site and every plane mu<nu of the periodic lattice, multiplies the
// four links of each plaquette with rounding and saturation, and returns the
// saturated sum of real parts, the plaquette count and a size flag (set,
// with zero sum and count, when the volume exceeds MAX_SITES). A measure
// sets up the strides, then walks via the single read port of the link
// store and one shared complex multiplier (read and load the first link,
// then read, multiply and round each further link, and accumulate). The
// next request is taken while a finished result still waits on the output.
// Configuration must be written only while the block is idle (unenforced).
module lattice_plaquette_sum #(
  parameter int MAX_SITES = lps_pkg::MAX_SITES_DEF,
  parameter int MAX_DIMS  = lps_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [lps_pkg::SITE_PORT_W-1:0]   in_site,
  input  logic [1:0]                        in_link_dir,
  input  logic signed [lps_pkg::PART_W-1:0] in_link_re,
  input  logic signed [lps_pkg::PART_W-1:0] in_link_im,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lps_pkg::SUM_W-1:0]  out_plaquette_sum,
  output logic [lps_pkg::COUNT_W-1:0]       out_plaquette_count,
  output logic                              out_size_error,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lps_pkg::*;

  cmd_t    cmd;
  status_t st;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: idle, setup of strides, volume check, then per plaquette read/load/multiply/round/accumulate
  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // link store, walk counters, multiplier and accumulator
  lps_datapath #(
    .MAX_SITES (MAX_SITES),
    .MAX_DIMS  (MAX_DIMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_site             (in_site),
    .in_link_dir         (in_link_dir),
    .in_link_re          (in_link_re),
    .in_link_im          (in_link_im),
    .out_plaquette_sum   (out_plaquette_sum),
    .out_plaquette_count (out_plaquette_count),
    .out_size_error      (out_size_error)
  );

endmodule

[rtl/lps_checker.sv]
`timescale 1ns / 1ps
module lps_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [lps_pkg::SUM_W-1:0]  out_plaquette_sum,
  input logic [lps_pkg::COUNT_W-1:0]       out_plaquette_count,
  input logic                              out_size_error
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  // oversized lattice gives empty result
  a_size_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |-> out_plaquette_sum == '0 && out_plaquette_count == '0)
    else $error("size error with nonzero sum or count");

  // measure needs setup cycles before a result appears
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> !$rose(out_valid))
    else $error("result too early after measure");

  // busy after a measure request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> !in_ready)
    else $error("request taken during measure");

endmodule

bind lattice_plaquette_sum lps_checker u_lps_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_kind             (in_kind),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_plaquette_sum   (out_plaquette_sum),
  .out_plaquette_count (out_plaquette_count),
  .out_size_error      (out_size_error)
);
